// ===== hdl/lbps_pkg.sv =====
package lbps_pkg;

   localparam int unsigned CMD_W   = 3;
   localparam int unsigned PAT_W   = 3;
   localparam int unsigned IDX_W   = 5;
   localparam int unsigned DUR_W   = 16;

   localparam logic [PAT_W-1:0] NUM_PATTERNS = 3'd7;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK        = 3'd0,
      CMD_SET_PATTERN = 3'd1,
      CMD_TURN_ON     = 3'd2,
      CMD_TURN_OFF    = 3'd3,
      CMD_TOGGLE      = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [PAT_W-1:0] pattern_id;
   } req_type;

   typedef struct packed {
      logic pin_level;
      logic led_lit;
      logic pattern_running;
      logic status;
   } rsp_type;

   // Phase durations in ms, all patterns back to back.
   function automatic logic [DUR_W-1:0] dur_rom(input logic [IDX_W-1:0] addr);
      logic [DUR_W-1:0] d;
      unique case (addr)
         5'd0, 5'd1:                      d = 16'd500;
         5'd2, 5'd3:                      d = 16'd100;
         5'd4, 5'd5, 5'd6:                d = 16'd250;
         5'd7, 5'd8:                      d = 16'd1000;
         5'd9:                            d = 16'd100;
         5'd10, 5'd11:                    d = 16'd300;
         5'd12, 5'd13:                    d = 16'd600;
         5'd20, 5'd22, 5'd24:             d = 16'd450;
         5'd31:                           d = 16'd1500;
         default:                         d = 16'd150;
      endcase
      return d;
   endfunction

   function automatic logic [IDX_W-1:0] pat_base(input logic [PAT_W-1:0] pat);
      logic [IDX_W-1:0] b;
      unique case (pat)
         3'd1:    b = 5'd2;
         3'd2:    b = 5'd4;
         3'd3:    b = 5'd8;
         3'd4:    b = 5'd10;
         3'd5:    b = 5'd12;
         3'd6:    b = 5'd14;
         default: b = 5'd0;
      endcase
      return b;
   endfunction

   function automatic logic [IDX_W-1:0] pat_len(input logic [PAT_W-1:0] pat);
      logic [IDX_W-1:0] l;
      unique case (pat)
         3'd2:    l = 5'd4;
         3'd6:    l = 5'd18;
         default: l = 5'd2;
      endcase
      return l;
   endfunction

   // Duration of one phase; an out-of-range pattern falls back to pattern 0 and an
   // out-of-range index to the pattern's first phase, and a zero duration counts as one.
   function automatic logic [DUR_W-1:0] phase_dur(input logic [PAT_W-1:0] pat,
                                                   input logic [IDX_W-1:0] idx);
      logic [PAT_W-1:0] p;
      logic [IDX_W-1:0] i;
      logic [DUR_W-1:0] d;
      p = (pat < NUM_PATTERNS) ? pat : '0;
      i = (idx < pat_len(p)) ? idx : '0;
      d = dur_rom(pat_base(p) + i);
      return (d == '0) ? DUR_W'(1) : d;
   endfunction

endpackage

// ===== hdl/lbps_in_stage.sv =====
module lbps_in_stage
   import lbps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   assign req_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         if (req_valid) begin
            item_in = req_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== hdl/lbps_core.sv =====
module lbps_core
   import lbps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    pin_invert,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   logic             lit_ff, lit_in;
   logic             running_ff, running_in;
   logic [PAT_W-1:0] pattern_ff, pattern_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [DUR_W-1:0] remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             take;
   logic             status;
   logic [PAT_W-1:0] cur_pat;
   logic [IDX_W:0]   index_inc;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;

   assign cur_pat   = (pattern_ff < NUM_PATTERNS) ? pattern_ff : '0;
   assign index_inc = {1'b0, index_ff} + 1'b1;

   always_comb begin
      lit_in     = lit_ff;
      running_in = running_ff;
      pattern_in = pattern_ff;
      index_in   = index_ff;
      remain_in  = remain_ff;
      status     = 1'b0;

      unique case (in_item.command)
         CMD_TICK: begin
            if (running_ff) begin
               if (remain_ff <= DUR_W'(1)) begin
                  // phase over: toggle, reload from the current index, step on
                  lit_in    = !lit_ff;
                  remain_in = phase_dur(cur_pat, index_ff);
                  index_in  = (index_inc >= {1'b0, pat_len(cur_pat)}) ? '0
                                                                      : index_inc[IDX_W-1:0];
               end else begin
                  remain_in = remain_ff - 1'b1;
               end
            end
         end
         CMD_SET_PATTERN: begin
            if (in_item.pattern_id < NUM_PATTERNS) begin
               lit_in     = 1'b0;
               running_in = 1'b1;
               pattern_in = in_item.pattern_id;
               index_in   = '0;
               remain_in  = phase_dur(in_item.pattern_id, '0);
            end else begin
               status = 1'b1;
            end
         end
         CMD_TURN_ON: begin
            running_in = 1'b0;
            lit_in     = 1'b1;
         end
         CMD_TURN_OFF: begin
            running_in = 1'b0;
            lit_in     = 1'b0;
         end
         CMD_TOGGLE: begin
            running_in = 1'b0;
            lit_in     = !lit_ff;
         end
         default: begin
         end
      endcase

      rsp_in.pin_level       = lit_in ^ pin_invert;
      rsp_in.led_lit         = lit_in;
      rsp_in.pattern_running = running_in;
      rsp_in.status          = status;

      rsp_valid_in = take ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff       <= 1'b0;
         running_ff   <= 1'b0;
         pattern_ff   <= '0;
         index_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            lit_ff     <= lit_in;
            running_ff <= running_in;
            pattern_ff <= pattern_in;
            index_ff   <= index_in;
            remain_ff  <= remain_in;
         end
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== hdl/led_blink_pattern_sequencer.sv =====
// Path from item accept to result accept: input register, then result register.
// Throughput: one item per cycle while results are taken; the LED state update is
// a single compare, decrement or ROM lookup between the two registers.
// Reset (synchronous, active high): LED off, no pattern running, phase index and
// countdown cleared, pin inversion cleared, both stages empty.
module led_blink_pattern_sequencer
   import lbps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   logic    pin_invert_ff, pin_invert_in;
   logic    stg_valid;
   logic    stg_ready;
   req_type stg_item;

   assign pin_invert_in = csr_wr_en ? csr_wr_data : pin_invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_invert_ff <= 1'b0;
      end else begin
         pin_invert_ff <= pin_invert_in;
      end
   end

   lbps_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .out_valid (stg_valid),
      .out_ready (stg_ready),
      .out_item  (stg_item)
   );

   lbps_core u_core (
      .clock      (clock),
      .reset      (reset),
      .pin_invert (pin_invert_ff),
      .in_valid   (stg_valid),
      .in_ready   (stg_ready),
      .in_item    (stg_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

   // Pin level is the LED state through the current polarity.
   a_pin_polarity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.pin_level == (rsp_item.led_lit ^ pin_invert_ff)))
      else $error("pin_level does not match led_lit and polarity");

   // A full input stage only takes a new item while it hands its item on.
   a_stage_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && stg_valid) |-> stg_ready)
      else $error("input stage overwritten");

   // Only a set-pattern item can flag a bad status.
   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      (stg_valid && stg_ready && (stg_item.command != CMD_SET_PATTERN)) |=>
         !rsp_item.status)
      else $error("status set for a command other than set pattern");

   // Results come out empty after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ===== dv/led_blink_checker.sv =====
`timescale 1ns / 100ps

module led_blink_checker
   import lbps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_item,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_item,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int unsigned errors,
   output int unsigned pending
);

   localparam int unsigned PAT_COUNT = NUM_PATTERNS;

   // phase durations in ms, patterns packed back to back
   localparam logic [DUR_W-1:0] PHASE_MS [32] = '{
      500, 500,
      100, 100,
      250, 250, 250, 1000,
      1000, 100,
      300, 300,
      600, 600,
      150, 150, 150, 150, 150, 150,
      450, 150, 450, 150, 450, 150,
      150, 150, 150, 150, 150, 1500
   };
   localparam logic [IDX_W-1:0] PAT_FIRST  [PAT_COUNT] = '{0, 2, 4, 8, 10, 12, 14};
   localparam logic [IDX_W-1:0] PAT_PHASES [PAT_COUNT] = '{2, 2, 4, 2, 2, 2, 18};

   logic             pin_invert;
   logic             lit;
   logic             running;
   logic [PAT_W-1:0] cur_pat;
   logic [IDX_W-1:0] phase;
   logic [DUR_W-1:0] remain_ms;
   rsp_type          led_expected[$];

   task automatic report(input string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
   endtask

   function automatic logic [DUR_W-1:0] load_ms(input logic [PAT_W-1:0] pat,
                                                input logic [IDX_W-1:0] idx);
      logic [PAT_W-1:0] p;
      logic [IDX_W-1:0] i;
      logic [DUR_W-1:0] d;
      p = (pat < NUM_PATTERNS) ? pat : '0;
      i = (idx < PAT_PHASES[p]) ? idx : '0;
      d = PHASE_MS[IDX_W'(PAT_FIRST[p] + i)];
      return (d == '0) ? DUR_W'(1) : d;
   endfunction

   task automatic led_predict(input req_type it, output rsp_type r);
      logic bad_id;
      bad_id = 1'b0;
      case (it.command)
         CMD_TICK: begin
            if (running) begin
               if (remain_ms <= DUR_W'(1)) begin
                  // phase over: flip the LED and load the next duration
                  lit       = ~lit;
                  remain_ms = load_ms(cur_pat, phase);
                  phase     = (phase + 1'b1 >= PAT_PHASES[cur_pat]) ? '0 : phase + 1'b1;
               end else begin
                  remain_ms = remain_ms - 1'b1;
               end
            end
         end
         CMD_SET_PATTERN: begin
            if (it.pattern_id < NUM_PATTERNS) begin
               lit       = 1'b0;
               running   = 1'b1;
               cur_pat   = it.pattern_id;
               phase     = '0;
               remain_ms = load_ms(it.pattern_id, '0);
            end else begin
               bad_id = 1'b1;
            end
         end
         CMD_TURN_ON: begin
            running = 1'b0;
            lit     = 1'b1;
         end
         CMD_TURN_OFF: begin
            running = 1'b0;
            lit     = 1'b0;
         end
         CMD_TOGGLE: begin
            running = 1'b0;
            lit     = ~lit;
         end
         default: ;
      endcase
      r.pin_level       = lit ^ pin_invert;
      r.led_lit         = lit;
      r.pattern_running = running;
      r.status          = bad_id;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         pin_invert = 1'b0;
         lit        = 1'b0;
         running    = 1'b0;
         cur_pat    = '0;
         phase      = '0;
         remain_ms  = '0;
         led_expected.delete();
      end else begin
         if (csr_wr_en) begin
            pin_invert = csr_wr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (led_expected.size() == 0) begin
               report($sformatf("result %b with no item pending", rsp_item));
            end else begin
               want = led_expected.pop_front();
               if (rsp_item.pin_level !== want.pin_level)
                  report($sformatf("pin_level: expected %b got %b",
                                   want.pin_level, rsp_item.pin_level));
               if (rsp_item.led_lit !== want.led_lit)
                  report($sformatf("led_lit: expected %b got %b",
                                   want.led_lit, rsp_item.led_lit));
               if (rsp_item.pattern_running !== want.pattern_running)
                  report($sformatf("pattern_running: expected %b got %b",
                                   want.pattern_running, rsp_item.pattern_running));
               if (rsp_item.status !== want.status)
                  report($sformatf("status: expected %b got %b",
                                   want.status, rsp_item.status));
            end
         end
         if (req_valid && req_ready) begin
            led_predict(req_item, want);
            led_expected.push_back(want);
         end
      end
      pending = led_expected.size();
   end

endmodule

// ===== dv/tb_led_blink_pattern_sequencer.sv =====
`timescale 1ns / 100ps

module tb_led_blink_pattern_sequencer;
   import lbps_pkg::*;

   localparam logic [CMD_W-1:0] CMD_CODE_LAST = 3'd7;   // codes past CMD_TOGGLE do nothing
   localparam logic [PAT_W-1:0] PAT_BAD       = NUM_PATTERNS;
   localparam logic [PAT_W-1:0] PAT_FAST      = 3'd1;
   localparam int unsigned      RUN_ITEMS     = 1100;
   localparam int unsigned      CHUNK_COUNT   = 4;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   req_type     req_item    = '0;
   logic        rsp_ready   = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   rsp_type     rsp_item;
   int unsigned errors;
   int unsigned pending;

   bit          calm         = 1'b0;
   bit          send_quiet   = 1'b0;
   bit          rsp_quiet    = 1'b0;
   bit          pattern_live = 1'b0;
   int unsigned stall_left   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   led_blink_pattern_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   led_blink_checker led_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .errors      (errors),
      .pending     (pending)
   );

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (!rsp_quiet && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) rsp_quiet = !rsp_quiet;
   end

   // called and returns at a falling edge; valid stays high across back-to-back items
   task automatic send_led_cmd(input logic [CMD_W-1:0] cmd, input logic [PAT_W-1:0] pid);
      int unsigned gap;
      if (!calm && !send_quiet && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_item.command    <= cmd;
      req_item.pattern_id <= pid;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      case (cmd)
         CMD_SET_PATTERN: if (pid < NUM_PATTERNS) pattern_live = 1'b1;
         CMD_TURN_ON, CMD_TURN_OFF, CMD_TOGGLE: pattern_live = 1'b0;
         default: ;
      endcase
      if ($urandom_range(0, 99) == 0) send_quiet = !send_quiet;
   endtask

   task automatic write_polarity(input logic value);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly ticks behind a live pattern, with commands and junk mixed in
   task automatic random_led_item(output bit counted);
      int unsigned      roll;
      logic [CMD_W-1:0] cmd;
      logic [PAT_W-1:0] pid;
      roll = $urandom_range(0, 99);
      pid  = PAT_W'($urandom());
      if ((!pattern_live && roll < 60) || roll < 4) begin
         cmd = CMD_SET_PATTERN;
         if ($urandom_range(0, 1) == 0) pid = PAT_FAST;
      end else if (roll < 8) begin
         cmd = CMD_W'($urandom_range(CMD_TURN_ON, CMD_TOGGLE));
      end else if (roll < 10) begin
         cmd = CMD_W'($urandom_range(CMD_TOGGLE + 1, CMD_CODE_LAST));
      end else begin
         cmd = CMD_TICK;
      end
      // idle ticks change nothing, so they don't count toward the run
      counted = !(cmd == CMD_TICK && !pattern_live);
      send_led_cmd(cmd, pid);
   endtask

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned sent;
      bit          counted;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_polarity(1'b0);
      send_led_cmd(CMD_TICK, PAT_BAD);
      send_led_cmd(CMD_SET_PATTERN, PAT_BAD);
      send_led_cmd(CMD_TURN_ON, 3'd0);
      send_led_cmd(CMD_TOGGLE, 3'd5);
      send_led_cmd(CMD_TOGGLE, 3'd2);
      send_led_cmd(CMD_TURN_OFF, 3'd3);
      for (int c = CMD_TOGGLE + 1; c <= CMD_CODE_LAST; c++) begin
         send_led_cmd(CMD_W'(c), PAT_W'(c));
      end
      for (int p = 0; p < NUM_PATTERNS; p++) begin
         send_led_cmd(CMD_SET_PATTERN, PAT_W'(p));
         send_led_cmd(CMD_TICK, PAT_W'(p));
      end
      send_led_cmd(CMD_TURN_ON, PAT_BAD);

      for (int chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
         if (chunk == CHUNK_COUNT - 1) begin
            write_polarity(1'($urandom_range(0, 1)));
            calm = 1'b1;
         end else begin
            write_polarity(chunk % 2 == 0);
         end
         sent = 0;
         while (sent < RUN_ITEMS / CHUNK_COUNT) begin
            random_led_item(counted);
            if (counted) sent++;
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
